// File: rtl/gnss_dfr_pkg.sv
package gnss_dfr_pkg;

  // Largest number of bytes that one frame or unknown run may hold.
  localparam int unsigned FRAME_CAPACITY = 2048;
  localparam int unsigned CNT_W = $clog2(FRAME_CAPACITY);

  // Byte count thresholds, one bit wider than the stored count so that the
  // incremented count can reach the capacity itself.
  localparam logic [CNT_W:0] CNT_CAPACITY = (CNT_W + 1)'(FRAME_CAPACITY);
  localparam logic [CNT_W:0] CNT_ONE      = (CNT_W + 1)'(1);
  localparam logic [CNT_W:0] CNT_SYNC2    = (CNT_W + 1)'(2);
  localparam logic [CNT_W:0] CNT_LEN_LO   = (CNT_W + 1)'(5);
  localparam logic [CNT_W:0] CNT_LEN_HI   = (CNT_W + 1)'(6);

  // UBX lengths are compared in 17 bits so the header overhead never wraps.
  localparam logic [16:0] UBX_LEN_MAX  = 17'(FRAME_CAPACITY - 8);
  localparam logic [16:0] UBX_OVERHEAD = 17'(8);

  // Stream bytes of interest.
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] UBX_SYNC1   = 8'hB5;
  localparam logic [7:0] UBX_SYNC2   = 8'h62;

  // Parser modes.
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_UNKNOWN = 2'd1;
  localparam logic [1:0] MODE_NMEA    = 2'd2;
  localparam logic [1:0] MODE_UBX     = 2'd3;

  // Frame kinds.
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_NMEA    = 2'd1;
  localparam logic [1:0] KIND_UBX     = 2'd2;

  // Outcome codes.
  localparam logic [2:0] OUT_OPEN      = 3'd0;
  localparam logic [2:0] OUT_NMEA_DONE = 3'd1;
  localparam logic [2:0] OUT_UBX_DONE  = 3'd2;
  localparam logic [2:0] OUT_UNK_FULL  = 3'd3;
  localparam logic [2:0] OUT_NO_CR     = 3'd4;
  localparam logic [2:0] OUT_NMEA_OVF  = 3'd5;
  localparam logic [2:0] OUT_BAD_SYNC  = 3'd6;
  localparam logic [2:0] OUT_TOO_LONG  = 3'd7;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CNT_W-1:0] count;
    logic [7:0]       len_low;
    logic [15:0]      pay_len;
    logic             prev_cr;
  } dfr_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] frame_kind;
    logic       first_of_frame;
    logic       last_of_frame;
    logic [2:0] outcome;
    logic       closes_prior_unknown;
  } dfr_result_t;

endpackage

// File: rtl/gnss_dfr_step.sv
module gnss_dfr_step (
  input  gnss_dfr_pkg::dfr_state_t  st,
  input  logic [7:0]                rx_byte,
  output gnss_dfr_pkg::dfr_state_t  st_next,
  output gnss_dfr_pkg::dfr_result_t res
);
  import gnss_dfr_pkg::*;

  logic [1:0]   mode_w;
  logic [CNT_W:0] cnt_w;
  logic [7:0]   len_low_w;
  logic [15:0]  pay_w;
  logic         cr_w;
  logic         is_marker;
  logic [16:0]  cnt_ext;

  assign is_marker = (rx_byte == CHAR_DOLLAR) || (rx_byte == UBX_SYNC1);

  always_comb begin
    mode_w    = st.mode;
    cnt_w     = {1'b0, st.count};
    len_low_w = st.len_low;
    pay_w     = st.pay_len;
    cr_w      = st.prev_cr;
    cnt_ext   = '0;
    res       = '0;
    res.data_byte = rx_byte;
    res.frame_kind = KIND_UNKNOWN;
    res.outcome    = OUT_OPEN;

    // A frame marker ends an unknown run before it opens its own frame.
    if (mode_w == MODE_UNKNOWN && is_marker) begin
      res.closes_prior_unknown = (st.count != '0);
      mode_w = MODE_IDLE;
    end

    if (mode_w == MODE_IDLE) begin
      res.first_of_frame = 1'b1;
      cnt_w     = '0;
      len_low_w = '0;
      pay_w     = '0;
      cr_w      = 1'b0;
      if (rx_byte == CHAR_DOLLAR) begin
        mode_w = MODE_NMEA;
      end else if (rx_byte == UBX_SYNC1) begin
        mode_w = MODE_UBX;
      end else begin
        mode_w = MODE_UNKNOWN;
      end
    end

    if (mode_w == MODE_UNKNOWN) begin
      res.frame_kind = KIND_UNKNOWN;
      if (cnt_w == '0) begin
        res.first_of_frame = 1'b1;
      end
      cnt_w = cnt_w + CNT_ONE;
      if (cnt_w >= CNT_CAPACITY) begin
        res.last_of_frame = 1'b1;
        res.outcome       = OUT_UNK_FULL;
        cnt_w             = '0;
      end
    end else if (mode_w == MODE_NMEA) begin
      res.frame_kind = KIND_NMEA;
      cnt_w = cnt_w + CNT_ONE;
      if (rx_byte == CHAR_LF) begin
        res.last_of_frame = 1'b1;
        res.outcome = (cnt_w >= CNT_SYNC2 && cr_w) ? OUT_NMEA_DONE : OUT_NO_CR;
      end else if (cnt_w >= CNT_CAPACITY) begin
        res.last_of_frame = 1'b1;
        res.outcome       = OUT_NMEA_OVF;
      end
      cr_w = (rx_byte == CHAR_CR);
    end else begin
      res.frame_kind = KIND_UBX;
      cnt_w = cnt_w + CNT_ONE;
      if (cnt_w == CNT_SYNC2 && rx_byte != UBX_SYNC2) begin
        res.last_of_frame = 1'b1;
        res.outcome       = OUT_BAD_SYNC;
      end else begin
        if (cnt_w == CNT_LEN_LO) begin
          len_low_w = rx_byte;
        end
        if (cnt_w == CNT_LEN_HI) begin
          pay_w = {rx_byte, len_low_w};
          if ({1'b0, pay_w} >= UBX_LEN_MAX) begin
            res.last_of_frame = 1'b1;
            res.outcome       = OUT_TOO_LONG;
          end
        end
        cnt_ext = {{(16 - CNT_W){1'b0}}, cnt_w};
        if (!res.last_of_frame && cnt_w >= CNT_LEN_HI &&
            cnt_ext == ({1'b0, pay_w} + UBX_OVERHEAD)) begin
          res.last_of_frame = 1'b1;
          res.outcome       = OUT_UBX_DONE;
        end
      end
    end

    if (res.last_of_frame && mode_w != MODE_UNKNOWN) begin
      mode_w = MODE_IDLE;
      cnt_w  = '0;
      cr_w   = 1'b0;
    end

    st_next.mode    = mode_w;
    st_next.count   = cnt_w[CNT_W-1:0];
    st_next.len_low = len_low_w;
    st_next.pay_len = pay_w;
    st_next.prev_cr = cr_w;
  end

endmodule

// File: rtl/gnss_nmea_ubx_stream_deframer_core.sv
// A byte transferred at a rising edge is registered in the input stage, and its tagged
// result is then registered in the result register that drives the output port.
// Throughput: one byte per cycle when not stalled; parse state updates once per byte.
// Reset (rst, synchronous, active high) empties both stages and returns the parser to idle
// with all counters and the stored UBX length cleared.
module gnss_nmea_ubx_stream_deframer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic [1:0] frame_kind,
  output logic       first_of_frame,
  output logic       last_of_frame,
  output logic [2:0] outcome,
  output logic       closes_prior_unknown
);
  import gnss_dfr_pkg::*;

  // Input stage: holds one byte until the result register can take it.
  logic        in_full;
  logic [7:0]  in_byte;

  // Parser state and the combinational step that advances it.
  dfr_state_t  state;
  dfr_state_t  state_next;
  dfr_result_t step_res;

  // Result register.
  dfr_result_t res;

  logic advance;

  // The byte in the input stage moves forward when the output register is
  // empty or its current result is being transferred in this cycle.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  gnss_dfr_step u_step (
    .st      (state),
    .rx_byte (in_byte),
    .st_next (state_next),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  // The parser state only moves when a byte is handed to the result
  // register, so the state always matches the most recent result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= step_res;
    end
  end

  assign data_byte            = res.data_byte;
  assign frame_kind           = res.frame_kind;
  assign first_of_frame       = res.first_of_frame;
  assign last_of_frame        = res.last_of_frame;
  assign outcome              = res.outcome;
  assign closes_prior_unknown = res.closes_prior_unknown;

`ifndef SYNTHESIS
  // Only a closing byte carries an outcome code.
  a_outcome_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((outcome != OUT_OPEN) == last_of_frame))
    else $error("outcome code does not match last_of_frame");

  // A marker that closes an unknown run always opens a real frame.
  a_close_opens_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && closes_prior_unknown) |-> (first_of_frame && frame_kind != KIND_UNKNOWN))
    else $error("closed unknown run without opening a frame");

  // A closed NMEA or UBX frame leaves the parser idle.
  a_idle_after_close: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_frame && frame_kind != KIND_UNKNOWN) |-> (state.mode == MODE_IDLE))
    else $error("parser not idle after a closed frame");

  // Unknown runs only report open or full.
  a_unknown_codes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_kind == KIND_UNKNOWN) |->
      (outcome == OUT_OPEN || outcome == OUT_UNK_FULL))
    else $error("bad outcome on an unknown run");
`endif

endmodule

// File: test/tb_top.sv
module tb_top;
  import gnss_dfr_pkg::*;

  localparam int HOLD_START   = 600;   // receiver cycle at which the long hold-off begins
  localparam int HOLD_END     = 900;
  localparam int CALM_START   = 150;   // window in which neither side idles
  localparam int CALM_END     = 450;
  localparam int GAP_PCT      = 10;
  localparam int TOTAL_BYTES  = 850;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] data_byte;
  logic [1:0] frame_kind;
  logic       first_of_frame;
  logic       last_of_frame;
  logic [2:0] outcome;
  logic       closes_prior_unknown;

  gnss_nmea_ubx_stream_deframer_core uut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .rx_byte              (rx_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .data_byte            (data_byte),
    .frame_kind           (frame_kind),
    .first_of_frame       (first_of_frame),
    .last_of_frame        (last_of_frame),
    .outcome              (outcome),
    .closes_prior_unknown (closes_prior_unknown)
  );

  logic [7:0]  pending_bytes[$];
  dfr_result_t tagged_bytes[$];
  dfr_result_t want_res;
  int          errors;
  int          snd_cycle;
  int          rcv_cycle;
  int          stall_cycles;
  logic        in_taken;

  // Parser state mirrored by the predictor.
  logic [1:0]       p_mode;
  logic [CNT_W-1:0] p_count;
  logic [7:0]       p_len_low;
  logic [15:0]      p_pay_len;
  logic             p_prev_cr;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Tags one byte and advances the mirrored parser state.
  function automatic dfr_result_t deframe_byte(input logic [7:0] c);
    dfr_result_t    r;
    logic [CNT_W:0] n;
    r = '0;
    r.data_byte = c;
    r.frame_kind = KIND_UNKNOWN;
    r.outcome = OUT_OPEN;
    // A marker inside an unknown run ends the run and opens a new frame.
    if (p_mode == MODE_UNKNOWN && (c == CHAR_DOLLAR || c == UBX_SYNC1)) begin
      r.closes_prior_unknown = (p_count != '0);
      p_mode = MODE_IDLE;
    end
    if (p_mode == MODE_IDLE) begin
      r.first_of_frame = 1'b1;
      p_count = '0;
      p_len_low = '0;
      p_pay_len = '0;
      p_prev_cr = 1'b0;
      if (c == CHAR_DOLLAR) p_mode = MODE_NMEA;
      else if (c == UBX_SYNC1) p_mode = MODE_UBX;
      else p_mode = MODE_UNKNOWN;
    end
    n = {1'b0, p_count} + CNT_ONE;
    case (p_mode)
      MODE_UNKNOWN: begin
        if (p_count == '0) r.first_of_frame = 1'b1;
        if (n >= CNT_CAPACITY) begin
          r.last_of_frame = 1'b1;
          r.outcome = OUT_UNK_FULL;
          n = '0;
        end
      end
      MODE_NMEA: begin
        r.frame_kind = KIND_NMEA;
        if (c == CHAR_LF) begin
          r.last_of_frame = 1'b1;
          r.outcome = (n >= CNT_SYNC2 && p_prev_cr) ? OUT_NMEA_DONE : OUT_NO_CR;
        end else if (n >= CNT_CAPACITY) begin
          r.last_of_frame = 1'b1;
          r.outcome = OUT_NMEA_OVF;
        end
        p_prev_cr = (c == CHAR_CR);
      end
      default: begin
        r.frame_kind = KIND_UBX;
        if (n == CNT_SYNC2 && c != UBX_SYNC2) begin
          r.last_of_frame = 1'b1;
          r.outcome = OUT_BAD_SYNC;
        end else begin
          if (n == CNT_LEN_LO) p_len_low = c;
          if (n == CNT_LEN_HI) begin
            p_pay_len = {c, p_len_low};
            if ({1'b0, p_pay_len} >= UBX_LEN_MAX) begin
              r.last_of_frame = 1'b1;
              r.outcome = OUT_TOO_LONG;
            end
          end
          if (!r.last_of_frame && n >= CNT_LEN_HI &&
              17'(n) == {1'b0, p_pay_len} + UBX_OVERHEAD) begin
            r.last_of_frame = 1'b1;
            r.outcome = OUT_UBX_DONE;
          end
        end
      end
    endcase
    // A full unknown run stays in unknown mode; every other close returns to idle.
    if (r.last_of_frame && p_mode != MODE_UNKNOWN) begin
      p_mode = MODE_IDLE;
      n = '0;
      p_prev_cr = 1'b0;
    end
    p_count = n[CNT_W-1:0];
    return r;
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] v;
    v = 8'($urandom_range(255));
    while (v == a || v == b) v = 8'($urandom_range(255));
    return v;
  endfunction

  // Appends one byte to the end of the stimulus queue.
  task automatic put_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  task automatic add_nmea(input int body_len, input bit with_cr, input bit with_lf);
    put_byte(CHAR_DOLLAR);
    repeat (body_len) begin
      // Mostly printable text, now and then any byte but LF.
      if ($urandom_range(7) != 0) put_byte(8'($urandom_range(8'h7E, 8'h20)));
      else put_byte(byte_except(CHAR_LF, CHAR_LF));
    end
    if (with_cr) put_byte(CHAR_CR);
    if (with_lf) put_byte(CHAR_LF);
  endtask

  task automatic add_ubx(input int pay_len);
    put_byte(UBX_SYNC1);
    put_byte(UBX_SYNC2);
    put_byte(8'($urandom_range(255)));
    put_byte(8'($urandom_range(255)));
    put_byte(8'(pay_len));
    put_byte(8'(pay_len >> 8));
    repeat (pay_len + 2) put_byte(8'($urandom_range(255)));
  endtask

  task automatic add_unknown(input int run_len);
    repeat (run_len) put_byte(byte_except(CHAR_DOLLAR, UBX_SYNC1));
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // Sender: offers the next pending byte once the current one is transferred.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte <= '0;
      snd_cycle <= 0;
    end else begin
      snd_cycle <= snd_cycle + 1;
      if (!in_valid || in_taken) begin
        if (pending_bytes.size() != 0 &&
            ((snd_cycle >= CALM_START && snd_cycle < CALM_END) ||
             $urandom_range(99) >= GAP_PCT)) begin
          in_valid <= 1'b1;
          rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, and a calm window.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rcv_cycle <= 0;
    end else begin
      rcv_cycle <= rcv_cycle + 1;
      if (rcv_cycle >= HOLD_START && rcv_cycle < HOLD_END) out_ready <= 1'b0;
      else if (rcv_cycle >= CALM_START && rcv_cycle < CALM_END) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= GAP_PCT);
    end
  end

  // Input transfers feed the predictor.
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (rst) begin
      p_mode = MODE_IDLE;
      p_count = '0;
      p_len_low = '0;
      p_pay_len = '0;
      p_prev_cr = 1'b0;
    end else if (in_valid && in_ready) begin
      tagged_bytes.insert(tagged_bytes.size(), deframe_byte(rx_byte));
    end
  end

  // Output transfers are checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (tagged_bytes.size() == 0) begin
        $display("%0t: result with nothing expected, data_byte %0h", $time, data_byte);
        errors++;
      end else begin
        want_res = tagged_bytes.pop_front();
        check_field("data_byte", want_res.data_byte, data_byte);
        check_field("frame_kind", 8'(want_res.frame_kind), 8'(frame_kind));
        check_field("first_of_frame", 8'(want_res.first_of_frame), 8'(first_of_frame));
        check_field("last_of_frame", 8'(want_res.last_of_frame), 8'(last_of_frame));
        check_field("outcome", 8'(want_res.outcome), 8'(outcome));
        check_field("closes_prior_unknown", 8'(want_res.closes_prior_unknown),
                    8'(closes_prior_unknown));
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("gnss_nmea_ubx_stream_deframer_core regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int pick;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    out_ready = 1'b0;
    in_taken = 1'b0;
    errors = 0;
    stall_cycles = 0;

    // Directed part: short unknown run with extreme bytes, closed by an NMEA sentence.
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h7F);
    add_nmea(6, 1, 1);
    add_nmea(0, 0, 1);      // LF right after the dollar
    add_nmea(4, 0, 1);      // LF without CR
    add_nmea(0, 1, 1);      // shortest good sentence
    add_ubx(0);
    put_byte(UBX_SYNC1);    // bad second sync byte
    put_byte(8'h00);
    put_byte(UBX_SYNC1);    // repeated first sync byte is also bad
    put_byte(UBX_SYNC1);
    // Lengths at and above the limit close on the sixth byte.
    put_byte(UBX_SYNC1);
    put_byte(UBX_SYNC2);
    put_byte(8'h01);
    put_byte(8'h02);
    put_byte(8'hF8);
    put_byte(8'h07);
    put_byte(UBX_SYNC1);
    put_byte(UBX_SYNC2);
    put_byte(8'h05);
    put_byte(8'h01);
    put_byte(8'hFF);
    put_byte(8'hFF);
    add_unknown(5);
    add_ubx(3);             // UBX sync ends the unknown run
    // A single plain byte opens a run that a dollar ends.
    put_byte(8'h41);
    add_nmea(3, 1, 1);

    // Random part: mostly well-formed frames, some broken ones and noise.
    while (pending_bytes.size() < TOTAL_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        add_nmea($urandom_range(20), $urandom_range(9) != 0, 1'b1);
      end else if (pick < 65) begin
        add_ubx(($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(16));
      end else if (pick < 78) begin
        add_unknown($urandom_range(12, 1));
      end else if (pick < 86) begin
        put_byte(UBX_SYNC1);
        put_byte(byte_except(UBX_SYNC2, UBX_SYNC2));
      end else begin
        repeat ($urandom_range(6, 1)) put_byte(8'($urandom_range(255)));
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (tagged_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("gnss_nmea_ubx_stream_deframer_core regression: pass");
    end else begin
      $display("gnss_nmea_ubx_stream_deframer_core regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/gnss_dfr_pkg.sv
rtl/gnss_dfr_step.sv
rtl/gnss_nmea_ubx_stream_deframer_core.sv
test/tb_top.sv
